/* sv/traffic_light_mode_controller_assert.svh */
// assertion macros for the traffic light mode controller checker
// expects clk and rst_n in the scope of use
`ifndef TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH
`define TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TLMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tlmc_pkg.sv */
`default_nettype none
package tlmc_pkg;

  localparam int DUR_W   = 16;
  localparam int LEVEL_W = 10;
  localparam int DUTY_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_EMERG  = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_EMERG = 3'd1;
  localparam logic [2:0] REQ_BLINK = 3'd2;
  localparam logic [2:0] REQ_POWER = 3'd3;
  localparam logic [2:0] REQ_SET   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 2'd2;

  localparam logic [DUR_W-1:0] RED_RST    = 16'd2000;
  localparam logic [DUR_W-1:0] YELLOW_RST = 16'd500;
  localparam logic [DUR_W-1:0] GREEN_RST  = 16'd2000;

  localparam logic [DUR_W-1:0] FLASH_TICKS   = 16'd300;
  localparam logic [DUR_W-1:0] BLINK_TICKS   = 16'd500;
  localparam logic [2:0]       FLASH_TOGGLES = 3'd6;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [1:0]         wanted_mode;
    logic [LEVEL_W-1:0] level;
  } tlmc_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] yellow_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [1:0]        mode_now;
  } tlmc_out_t;

  // level*255/1023: p = q0*1024 + lo = q0*1023 + (q0 + lo), remainder stays below 2*1023
  function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
    logic [17:0]       prod;
    logic [DUTY_W-1:0] q0;
    logic [10:0]       rem;
    prod = 18'(lvl) * 18'd255;
    q0   = prod[17:10];
    rem  = {1'b0, prod[9:0]} + 11'(q0);
    return (rem >= 11'd1023) ? q0 + 8'd1 : q0;
  endfunction

endpackage
`default_nettype wire

/* sv/traffic_light_mode_controller.sv */
// channel | ports                                 | moves
// input   | in_valid, in_stall, in_word           | one event word: request, mode, level
// result  | out_valid, out_stall, out_word        | one lamp/mode word per event
// config  | cfg_we, cfg_idx, cfg_wdata            | phase durations, index 0..2
//
// one event per clock while in_stall is low: the whole update is one combinational
// pass from the state registers into the output register (or the skid word below)
// a second word register behind the output takes one event while out_stall holds;
// in_stall rises only when both are full
// rst_n is synchronous: normal mode, red phase, all lamps dark, default durations
`default_nettype none
module traffic_light_mode_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  tlmc_pkg::tlmc_in_t                    in_word,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output tlmc_pkg::tlmc_out_t                   out_word,
  input  wire                                   cfg_we,
  input  wire [tlmc_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire [tlmc_pkg::DUR_W-1:0]             cfg_wdata
);
  import tlmc_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > DUR_W) ? TIMER_WIDTH : DUR_W;
  localparam logic [CMP_W-1:0] TMAX_X = CMP_W'({TIMER_WIDTH{1'b1}});

  typedef enum logic [2:0] {
    PH_RED, PH_YEL1, PH_GRN, PH_FLASH, PH_YEL2
  } phase_t;

  function automatic logic [TIMER_WIDTH-1:0] sat_dur(input logic [DUR_W-1:0] d);
    logic [CMP_W-1:0] dx;
    dx = CMP_W'(d);
    if (dx > TMAX_X) dx = TMAX_X;
    if (dx == '0) dx = CMP_W'(1);
    return TIMER_WIDTH'(dx);
  endfunction

  logic [DUR_W-1:0]       red_time_r, yellow_time_r, green_time_r;
  logic [1:0]             mode_r, mode_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [2:0]             fcnt_r, fcnt_nxt;
  logic                   fon_r, fon_nxt;
  logic [DUTY_W-1:0]      red_r, red_nxt, yel_r, yel_nxt, grn_r, grn_nxt;

  logic                   out_valid_r, skid_valid_r;
  tlmc_out_t              out_word_r, skid_word_r, res_word;

  logic                   in_acc, out_take;
  logic [DUTY_W-1:0]      duty;
  logic [DUR_W-1:0]       dur_sel;
  logic [TIMER_WIDTH-1:0] tmr_inc;
  logic                   hit;
  logic [2:0]             fcnt_inc;
  logic                   enter_en;
  logic [1:0]             enter_m;
  logic [DUTY_W-1:0]      blink_d;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_take  = out_valid_r && !out_stall;

  assign duty     = duty_of(in_word.level);
  assign tmr_inc  = timer_r + TIMER_WIDTH'(1);
  assign fcnt_inc = fcnt_r + 3'd1;

  always_comb begin
    if (mode_r == MODE_NORMAL) begin
      case (phase_r)
        PH_YEL1, PH_YEL2: dur_sel = yellow_time_r;
        PH_GRN:           dur_sel = green_time_r;
        PH_FLASH:         dur_sel = FLASH_TICKS;
        default:          dur_sel = red_time_r;
      endcase
    end else begin
      dur_sel = BLINK_TICKS;
    end
  end

  assign hit     = (tmr_inc >= sat_dur(dur_sel));
  assign blink_d = fon_r ? '0 : duty;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    fcnt_nxt  = fcnt_r;
    fon_nxt   = fon_r;
    red_nxt   = red_r;
    yel_nxt   = yel_r;
    grn_nxt   = grn_r;
    enter_en  = 1'b0;
    enter_m   = MODE_NORMAL;

    case (in_word.req_type)
      REQ_TICK: begin
        case (mode_r)
          MODE_NORMAL: begin
            timer_nxt = hit ? '0 : tmr_inc;
            case (phase_r)
              PH_YEL1: begin
                if (hit) begin
                  red_nxt   = '0;
                  yel_nxt   = '0;
                  grn_nxt   = duty;
                  phase_nxt = PH_GRN;
                end
              end
              PH_GRN: begin
                if (hit) begin
                  red_nxt   = '0;
                  yel_nxt   = '0;
                  grn_nxt   = '0;
                  fon_nxt   = 1'b0;
                  fcnt_nxt  = '0;
                  phase_nxt = PH_FLASH;
                end
              end
              PH_FLASH: begin
                if (hit) begin
                  fon_nxt  = !fon_r;
                  grn_nxt  = blink_d;
                  fcnt_nxt = fcnt_inc;
                  // six toggles done, on to the second yellow
                  if (fcnt_inc >= FLASH_TOGGLES) begin
                    red_nxt   = '0;
                    grn_nxt   = '0;
                    fon_nxt   = 1'b0;
                    fcnt_nxt  = '0;
                    yel_nxt   = duty;
                    phase_nxt = PH_YEL2;
                  end
                end
              end
              PH_YEL2: begin
                if (hit) begin
                  red_nxt   = duty;
                  yel_nxt   = '0;
                  grn_nxt   = '0;
                  phase_nxt = PH_RED;
                end
              end
              default: begin
                phase_nxt = PH_RED;
                if (hit) begin
                  red_nxt   = '0;
                  yel_nxt   = duty;
                  grn_nxt   = '0;
                  phase_nxt = PH_YEL1;
                end
              end
            endcase
          end
          MODE_EMERG, MODE_BLINK: begin
            timer_nxt = hit ? '0 : tmr_inc;
            if (hit) begin
              fon_nxt = !fon_r;
              red_nxt = blink_d;
              yel_nxt = (mode_r == MODE_BLINK) ? blink_d : '0;
              grn_nxt = (mode_r == MODE_BLINK) ? blink_d : '0;
            end
          end
          default: begin
            red_nxt = '0;
            yel_nxt = '0;
            grn_nxt = '0;
          end
        endcase
      end
      REQ_EMERG: begin
        enter_en = 1'b1;
        enter_m  = (mode_r == MODE_EMERG) ? MODE_NORMAL : MODE_EMERG;
      end
      REQ_BLINK: begin
        enter_en = 1'b1;
        enter_m  = (mode_r == MODE_BLINK) ? MODE_NORMAL : MODE_BLINK;
      end
      REQ_POWER: begin
        enter_en = 1'b1;
        enter_m  = (mode_r == MODE_OFF) ? MODE_NORMAL : MODE_OFF;
      end
      REQ_SET: begin
        enter_en = (in_word.wanted_mode != mode_r);
        enter_m  = in_word.wanted_mode;
      end
      default: begin
      end
    endcase

    // mode entry restarts everything at red
    if (enter_en) begin
      mode_nxt  = enter_m;
      phase_nxt = PH_RED;
      timer_nxt = '0;
      fcnt_nxt  = '0;
      fon_nxt   = 1'b0;
      red_nxt   = (enter_m == MODE_NORMAL) ? duty : '0;
      yel_nxt   = '0;
      grn_nxt   = '0;
    end
  end

  always_comb begin
    res_word.red_duty    = red_nxt;
    res_word.yellow_duty = yel_nxt;
    res_word.green_duty  = grn_nxt;
    res_word.mode_now    = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_time_r    <= RED_RST;
      yellow_time_r <= YELLOW_RST;
      green_time_r  <= GREEN_RST;
      mode_r        <= MODE_NORMAL;
      phase_r       <= PH_RED;
      timer_r       <= '0;
      fcnt_r        <= '0;
      fon_r         <= 1'b0;
      red_r         <= '0;
      yel_r         <= '0;
      grn_r         <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RED:    red_time_r    <= cfg_wdata;
          CFG_YELLOW: yellow_time_r <= cfg_wdata;
          CFG_GREEN:  green_time_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        mode_r  <= mode_nxt;
        phase_r <= phase_nxt;
        timer_r <= timer_nxt;
        fcnt_r  <= fcnt_nxt;
        fon_r   <= fon_nxt;
        red_r   <= red_nxt;
        yel_r   <= yel_nxt;
        grn_r   <= grn_nxt;
      end

      // output word register with one skid word behind it
      if (out_take || !out_valid_r) begin
        if (skid_valid_r) begin
          out_word_r   <= skid_word_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (in_acc) begin
          out_word_r  <= res_word;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_acc) begin
        skid_word_r  <= res_word;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/tlmc_checker.sv */
`default_nettype none
`include "traffic_light_mode_controller_assert.svh"
module tlmc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input tlmc_pkg::tlmc_out_t out_word
);
  import tlmc_pkg::*;

  logic r_on, y_on, g_on;

  assign r_on = (out_word.red_duty != '0);
  assign y_on = (out_word.yellow_duty != '0);
  assign g_on = (out_word.green_duty != '0);

  `TLMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")
  `TLMC_ASSERT_NOW(a_off_dark, out_valid && (out_word.mode_now == MODE_OFF), !r_on && !y_on && !g_on, "lamp lit in off mode")
  `TLMC_ASSERT_NOW(a_emerg_red_only, out_valid && (out_word.mode_now == MODE_EMERG), !y_on && !g_on, "yellow or green lit in emergency mode")
  `TLMC_ASSERT_NOW(a_normal_one_lamp, out_valid && (out_word.mode_now == MODE_NORMAL), !(r_on && y_on) && !(r_on && g_on) && !(y_on && g_on), "more than one lamp lit in normal mode")

endmodule

bind traffic_light_mode_controller tlmc_checker u_tlmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire
